>>> rtl/core/stt_pkg.sv
// Shared types, codes and character tables for the source text tokenizer.
package stt_pkg;

  localparam int KeywordMaxLenDefault = 8;
  localparam int PositionBitsDefault  = 16;
  localparam int MaxResults           = 5;

  // Token kinds
  localparam logic [5:0] KIND_END     = 6'd0;
  localparam logic [5:0] KIND_IDENT   = 6'd1;
  localparam logic [5:0] KIND_INT     = 6'd2;
  localparam logic [5:0] KIND_DEC     = 6'd3;
  localparam logic [5:0] KIND_STRING  = 6'd4;
  localparam logic [5:0] KIND_DIRECT  = 6'd5;
  localparam logic [5:0] KIND_KW_BASE = 6'd6;
  localparam logic [5:0] KIND_LPAREN  = 6'd27;
  localparam logic [5:0] KIND_RPAREN  = 6'd28;
  localparam logic [5:0] KIND_LBRACE  = 6'd29;
  localparam logic [5:0] KIND_RBRACE  = 6'd30;
  localparam logic [5:0] KIND_LBRACK  = 6'd31;
  localparam logic [5:0] KIND_RBRACK  = 6'd32;
  localparam logic [5:0] KIND_LE      = 6'd33;
  localparam logic [5:0] KIND_LT      = 6'd34;
  localparam logic [5:0] KIND_GE      = 6'd35;
  localparam logic [5:0] KIND_GT      = 6'd36;
  localparam logic [5:0] KIND_COMMA   = 6'd37;
  localparam logic [5:0] KIND_COLON   = 6'd38;
  localparam logic [5:0] KIND_SEMI    = 6'd39;
  localparam logic [5:0] KIND_PLUS    = 6'd40;
  localparam logic [5:0] KIND_ARROW   = 6'd41;
  localparam logic [5:0] KIND_MINUS   = 6'd42;
  localparam logic [5:0] KIND_STAR    = 6'd43;
  localparam logic [5:0] KIND_SLASH   = 6'd44;
  localparam logic [5:0] KIND_PERCENT = 6'd45;
  localparam logic [5:0] KIND_EQEQ    = 6'd46;
  localparam logic [5:0] KIND_ASSIGN  = 6'd47;
  localparam logic [5:0] KIND_NE      = 6'd48;
  localparam logic [5:0] KIND_NOT     = 6'd21;
  localparam logic [5:0] KIND_RANGEQ  = 6'd49;
  localparam logic [5:0] KIND_RANGE   = 6'd50;

  // Error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_UNTERM  = 3'd1;
  localparam logic [2:0] ERR_INCLUDE = 3'd2;
  localparam logic [2:0] ERR_DOT     = 3'd3;
  localparam logic [2:0] ERR_BADCHAR = 3'd4;

  // Scanner modes
  typedef enum logic [11:0] {
    M_IDLE    = 12'b0000_0000_0001,
    M_IDENT   = 12'b0000_0000_0010,
    M_NUM     = 12'b0000_0000_0100,
    M_NUMDOT  = 12'b0000_0000_1000,
    M_FLOAT   = 12'b0000_0001_0000,
    M_STR     = 12'b0000_0010_0000,
    M_ESC     = 12'b0000_0100_0000,
    M_COMMENT = 12'b0000_1000_0000,
    M_HASH    = 12'b0001_0000_0000,
    M_PEND    = 12'b0010_0000_0000,
    M_DOT     = 12'b0100_0000_0000,
    M_DOTDOT  = 12'b1000_0000_0000
  } mode_e;

  // Keyword spellings, first character in the low byte
  localparam logic [63:0] KW_TEXT [21] = '{
    64'("nf"), 64'("tel"), 64'("tum"), 64'("fi"), 64'("esle"), 64'("elihw"),
    64'("rof"), 64'("ni"), 64'("nruter"), 64'("kaerb"), 64'("eunitnoc"),
    64'("eurt"), 64'("eslaf"), 64'("dna"), 64'("ro"), 64'("ton"), 64'("tni"),
    64'("taolf"), 64'("loob"), 64'("gnirts"), 64'("diov")};
  localparam logic [4:0] KW_LEN [21] = '{
    5'd2, 5'd3, 5'd3, 5'd2, 5'd4, 5'd5, 5'd3, 5'd2, 5'd6, 5'd5, 5'd8,
    5'd4, 5'd5, 5'd3, 5'd2, 5'd3, 5'd3, 5'd5, 5'd4, 5'd6, 5'd4};
  localparam logic [63:0] PROFIT_TEXT  = 64'("tiforp");
  localparam logic [63:0] INCLUDE_TEXT = 64'("edulcni");

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic word_is(logic [63:0] w, logic [4:0] len,
                                   logic [63:0] t, logic [4:0] n);
    logic ok;
    ok = (len == n);
    for (int j = 0; j < 8; j++) begin
      if (5'(j) < n && w[8*j +: 8] != t[8*j +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [5:0] kw_kind(logic [63:0] w, logic [4:0] len);
    logic [5:0] k;
    k = KIND_IDENT;
    for (int i = 20; i >= 0; i--) begin
      if (word_is(w, len, KW_TEXT[i], KW_LEN[i])) k = KIND_KW_BASE + 6'(i);
    end
    return k;
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "[":     k = KIND_LBRACK;
      "]":     k = KIND_RBRACK;
      ",":     k = KIND_COMMA;
      ":":     k = KIND_COLON;
      ";":     k = KIND_SEMI;
      "+":     k = KIND_PLUS;
      "*":     k = KIND_STAR;
      "%":     k = KIND_PERCENT;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/core/stt_if.sv
// Channel interfaces: source bytes in, token beats out.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_byte;
  modport source (output valid, req_type, in_byte, input ready);
  modport sink (input valid, req_type, in_byte, output ready);
endinterface

interface stt_out_if #(parameter int PosBits = 16);
  logic               valid;
  logic               ready;
  logic               is_token;
  logic [7:0]         text_byte;
  logic [5:0]         token_kind;
  logic [PosBits-1:0] start_line;
  logic [PosBits-1:0] start_col;
  logic [2:0]         error_code;
  logic               last_of_run;
  modport source (output valid, is_token, text_byte, token_kind, start_line, start_col,
                  error_code, last_of_run, input ready);
  modport sink (input valid, is_token, text_byte, token_kind, start_line, start_col,
                error_code, last_of_run, output ready);
endinterface

>>> rtl/core/stt_front.sv
// Front end: scans one source byte per beat and builds the burst of result beats.
module stt_front #(
  parameter int KeywordMaxLen = stt_pkg::KeywordMaxLenDefault,
  parameter int PositionBits  = stt_pkg::PositionBitsDefault,
  localparam int RecW = 19 + 2 * PositionBits,
  localparam int EntW = 3 + stt_pkg::MaxResults * RecW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_req_type_i,
  input  logic [7:0]      in_byte_i,
  output logic            in_ready_o,
  output logic            push_o,
  output logic [EntW-1:0] push_data_o,
  input  logic            q_ready_i
);

  localparam int WIdxW = $clog2(KeywordMaxLen);
  localparam int WLenW = $clog2(KeywordMaxLen + 2);
  localparam logic [PositionBits-1:0] PosMax = '1;
  localparam logic [PositionBits-1:0] PosOne = PositionBits'(1);

  typedef struct packed {
    logic                    last;
    logic                    is_token;
    logic [7:0]              text_byte;
    logic [5:0]              kind;
    logic [PositionBits-1:0] line;
    logic [PositionBits-1:0] col;
    logic [2:0]              err;
  } rec_t;

  typedef struct packed {
    logic [2:0] cnt;
    rec_t [stt_pkg::MaxResults-1:0] recs;
  } ent_t;

  function automatic rec_t f_txt(logic [7:0] b);
    rec_t r;
    r = '0;
    r.text_byte = b;
    return r;
  endfunction

  function automatic rec_t f_rec(logic [5:0] k, logic [PositionBits-1:0] l,
                                 logic [PositionBits-1:0] c, logic [2:0] e);
    rec_t r;
    r = '0;
    r.is_token = 1'b1;
    r.kind = k;
    r.line = l;
    r.col = c;
    r.err = e;
    return r;
  endfunction

  logic [PositionBits-1:0] line_q, col_q, tok_line_q, tok_col_q, dot_line_q, dot_col_q;
  logic [PositionBits-1:0] line_d, col_d, tok_line_d, tok_col_d, dot_line_d, dot_col_d;
  stt_pkg::mode_e          mode_q, mode_d;
  logic [7:0]              held_q, held_d;
  logic [7:0]              word_q [KeywordMaxLen];
  logic [7:0]              word_d [KeywordMaxLen];
  logic [WLenW-1:0]        wlen_q, wlen_d;
  logic                    halted_q, halted_d;

  rec_t       res [stt_pkg::MaxResults];
  logic [2:0] n;
  logic       fire, eos, do_start, do_pend, has_c, used;
  logic [7:0] c, ec;
  logic [63:0] w8;
  logic [4:0]  wl5;
  logic [5:0]  one_k, two_k, sk;
  ent_t        ent;

  assign in_ready_o = q_ready_i;
  assign fire = in_valid_i && in_ready_o;

  // Keyword view of the word buffer
  always_comb begin
    for (int j = 0; j < 8; j++) w8[8*j +: 8] = word_q[j];
    wl5 = (wlen_q > WLenW'(8)) ? 5'd31 : 5'(wlen_q);
  end

  // Scan one byte: update state and collect the result beats in order
  always_comb begin
    line_d = line_q; col_d = col_q; tok_line_d = tok_line_q; tok_col_d = tok_col_q;
    dot_line_d = dot_line_q; dot_col_d = dot_col_q; mode_d = mode_q; held_d = held_q;
    word_d = word_q; wlen_d = wlen_q; halted_d = halted_q;
    for (int i = 0; i < stt_pkg::MaxResults; i++) res[i] = '0;
    n = '0; do_start = 1'b0; do_pend = 1'b0; has_c = 1'b0; used = 1'b0;
    one_k = stt_pkg::KIND_END; two_k = stt_pkg::KIND_END; sk = stt_pkg::KIND_END;
    ec = '0;
    c = in_byte_i;
    eos = in_req_type_i || (in_byte_i == 8'h00);

    if (fire && !halted_q) begin
      if (eos) begin
        // Close whatever token is open
        unique case (mode_q)
          stt_pkg::M_IDENT: begin
            res[n] = f_rec(stt_pkg::kw_kind(w8, wl5), tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
            n = n + 3'd1;
          end
          stt_pkg::M_NUM: begin
            res[n] = f_rec(stt_pkg::KIND_INT, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
            n = n + 3'd1;
          end
          stt_pkg::M_NUMDOT: begin
            res[n] = f_rec(stt_pkg::KIND_INT, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
            n = n + 3'd1;
            res[n] = f_rec(stt_pkg::KIND_END, dot_line_q, dot_col_q, stt_pkg::ERR_DOT);
            n = n + 3'd1;
            halted_d = 1'b1; mode_d = stt_pkg::M_IDLE;
          end
          stt_pkg::M_FLOAT: begin
            res[n] = f_rec(stt_pkg::KIND_DEC, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
            n = n + 3'd1;
          end
          stt_pkg::M_STR, stt_pkg::M_ESC: begin
            res[n] = f_rec(stt_pkg::KIND_END, tok_line_d, tok_col_d, stt_pkg::ERR_UNTERM);
            n = n + 3'd1;
            halted_d = 1'b1; mode_d = stt_pkg::M_IDLE;
          end
          stt_pkg::M_HASH: begin
            mode_d = stt_pkg::M_IDLE;
            if (stt_pkg::word_is(w8, wl5, stt_pkg::PROFIT_TEXT, 5'd6)) begin
              res[n] = f_rec(stt_pkg::KIND_DIRECT, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
              n = n + 3'd1;
            end else if (stt_pkg::word_is(w8, wl5, stt_pkg::INCLUDE_TEXT, 5'd7)) begin
              res[n] = f_rec(stt_pkg::KIND_END, tok_line_d, tok_col_d, stt_pkg::ERR_INCLUDE);
              n = n + 3'd1;
              halted_d = 1'b1;
            end
          end
          stt_pkg::M_PEND: do_pend = 1'b1;
          stt_pkg::M_DOT: begin
            res[n] = f_rec(stt_pkg::KIND_END, tok_line_d, tok_col_d, stt_pkg::ERR_DOT);
            n = n + 3'd1;
            halted_d = 1'b1; mode_d = stt_pkg::M_IDLE;
          end
          stt_pkg::M_DOTDOT: begin
            res[n] = f_txt("."); n = n + 3'd1;
            res[n] = f_txt("."); n = n + 3'd1;
            res[n] = f_rec(stt_pkg::KIND_RANGE, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
            n = n + 3'd1;
          end
          default: ;
        endcase
      end else begin
        // Advance the saturating position counters
        if (c == 8'h0A) begin
          if (line_q != PosMax) line_d = line_q + PosOne;
          col_d = PosOne;
        end else if (col_q != PosMax) begin
          col_d = col_q + PosOne;
        end
        unique case (mode_q)
          stt_pkg::M_IDENT: begin
            if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c) || c == "_") begin
              if (wlen_q < WLenW'(KeywordMaxLen)) word_d[wlen_q[WIdxW-1:0]] = c;
              if (wlen_q <= WLenW'(KeywordMaxLen)) wlen_d = wlen_q + WLenW'(1);
              res[n] = f_txt(c); n = n + 3'd1;
            end else begin
              res[n] = f_rec(stt_pkg::kw_kind(w8, wl5), tok_line_d, tok_col_d,
                             stt_pkg::ERR_NONE);
              n = n + 3'd1;
              do_start = 1'b1;
            end
          end
          stt_pkg::M_NUM: begin
            if (stt_pkg::is_digit(c)) begin
              res[n] = f_txt(c); n = n + 3'd1;
            end else if (c == ".") begin
              dot_line_d = line_q; dot_col_d = col_q; mode_d = stt_pkg::M_NUMDOT;
            end else begin
              res[n] = f_rec(stt_pkg::KIND_INT, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
              n = n + 3'd1;
              do_start = 1'b1;
            end
          end
          stt_pkg::M_NUMDOT: begin
            if (stt_pkg::is_digit(c)) begin
              res[n] = f_txt("."); n = n + 3'd1;
              res[n] = f_txt(c); n = n + 3'd1;
              mode_d = stt_pkg::M_FLOAT;
            end else begin
              res[n] = f_rec(stt_pkg::KIND_INT, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
              n = n + 3'd1;
              tok_line_d = dot_line_q; tok_col_d = dot_col_q;
              if (c == ".") begin
                mode_d = stt_pkg::M_DOTDOT;
              end else begin
                res[n] = f_rec(stt_pkg::KIND_END, dot_line_q, dot_col_q, stt_pkg::ERR_DOT);
                n = n + 3'd1;
                halted_d = 1'b1; mode_d = stt_pkg::M_IDLE;
              end
            end
          end
          stt_pkg::M_FLOAT: begin
            if (stt_pkg::is_digit(c)) begin
              res[n] = f_txt(c); n = n + 3'd1;
            end else begin
              res[n] = f_rec(stt_pkg::KIND_DEC, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
              n = n + 3'd1;
              do_start = 1'b1;
            end
          end
          stt_pkg::M_STR: begin
            if (c == "\"") begin
              res[n] = f_rec(stt_pkg::KIND_STRING, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
              n = n + 3'd1;
              mode_d = stt_pkg::M_IDLE;
            end else if (c == "\\") begin
              mode_d = stt_pkg::M_ESC;
            end else begin
              res[n] = f_txt(c); n = n + 3'd1;
            end
          end
          stt_pkg::M_ESC: begin
            if (c == "n") ec = 8'h0A;
            else if (c == "t") ec = 8'h09;
            else if (c == "r") ec = 8'h0D;
            else ec = c;
            res[n] = f_txt(ec); n = n + 3'd1;
            mode_d = stt_pkg::M_STR;
          end
          stt_pkg::M_COMMENT: begin
            if (c == 8'h0A) mode_d = stt_pkg::M_IDLE;
          end
          stt_pkg::M_HASH: begin
            if (stt_pkg::is_alpha(c)) begin
              if (wlen_q < WLenW'(KeywordMaxLen)) word_d[wlen_q[WIdxW-1:0]] = c;
              if (wlen_q <= WLenW'(KeywordMaxLen)) wlen_d = wlen_q + WLenW'(1);
            end else if (stt_pkg::word_is(w8, wl5, stt_pkg::PROFIT_TEXT, 5'd6)) begin
              res[n] = f_rec(stt_pkg::KIND_DIRECT, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
              n = n + 3'd1;
              do_start = 1'b1;
            end else if (stt_pkg::word_is(w8, wl5, stt_pkg::INCLUDE_TEXT, 5'd7)) begin
              res[n] = f_rec(stt_pkg::KIND_END, tok_line_d, tok_col_d, stt_pkg::ERR_INCLUDE);
              n = n + 3'd1;
              halted_d = 1'b1; mode_d = stt_pkg::M_IDLE;
            end else begin
              mode_d = (c == 8'h0A) ? stt_pkg::M_IDLE : stt_pkg::M_COMMENT;
            end
          end
          stt_pkg::M_PEND: begin
            do_pend = 1'b1; has_c = 1'b1;
          end
          stt_pkg::M_DOT: begin
            if (c == ".") begin
              mode_d = stt_pkg::M_DOTDOT;
            end else begin
              res[n] = f_rec(stt_pkg::KIND_END, tok_line_d, tok_col_d, stt_pkg::ERR_DOT);
              n = n + 3'd1;
              halted_d = 1'b1; mode_d = stt_pkg::M_IDLE;
            end
          end
          stt_pkg::M_DOTDOT: begin
            mode_d = stt_pkg::M_IDLE;
            res[n] = f_txt("."); n = n + 3'd1;
            res[n] = f_txt("."); n = n + 3'd1;
            if (c == "=") begin
              res[n] = f_txt("="); n = n + 3'd1;
              res[n] = f_rec(stt_pkg::KIND_RANGEQ, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
              n = n + 3'd1;
            end else begin
              res[n] = f_rec(stt_pkg::KIND_RANGE, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
              n = n + 3'd1;
              do_start = 1'b1;
            end
          end
          default: do_start = 1'b1;
        endcase
      end

      // Resolve a held one- or two-character operator
      if (do_pend) begin
        mode_d = stt_pkg::M_IDLE;
        if (held_q == "/") begin
          if (has_c && c == "/") begin
            mode_d = stt_pkg::M_COMMENT; used = 1'b1;
          end else begin
            res[n] = f_txt("/"); n = n + 3'd1;
            res[n] = f_rec(stt_pkg::KIND_SLASH, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
            n = n + 3'd1;
          end
        end else if (held_q == "-") begin
          res[n] = f_txt("-"); n = n + 3'd1;
          if (has_c && c == ">") begin
            res[n] = f_txt(">"); n = n + 3'd1;
            res[n] = f_rec(stt_pkg::KIND_ARROW, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
            n = n + 3'd1;
            used = 1'b1;
          end else begin
            res[n] = f_rec(stt_pkg::KIND_MINUS, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
            n = n + 3'd1;
          end
        end else begin
          if (held_q == "<") begin
            two_k = stt_pkg::KIND_LE; one_k = stt_pkg::KIND_LT;
          end else if (held_q == ">") begin
            two_k = stt_pkg::KIND_GE; one_k = stt_pkg::KIND_GT;
          end else if (held_q == "=") begin
            two_k = stt_pkg::KIND_EQEQ; one_k = stt_pkg::KIND_ASSIGN;
          end else begin
            two_k = stt_pkg::KIND_NE; one_k = stt_pkg::KIND_NOT;
          end
          res[n] = f_txt(held_q); n = n + 3'd1;
          if (has_c && c == "=") begin
            res[n] = f_txt("="); n = n + 3'd1;
            res[n] = f_rec(two_k, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
            n = n + 3'd1;
            used = 1'b1;
          end else begin
            res[n] = f_rec(one_k, tok_line_d, tok_col_d, stt_pkg::ERR_NONE);
            n = n + 3'd1;
          end
        end
        if (has_c && !used) do_start = 1'b1;
      end

      // Start a new token at this byte
      if (do_start) begin
        tok_line_d = line_q; tok_col_d = col_q; mode_d = stt_pkg::M_IDLE;
        sk = stt_pkg::single_kind(c);
        if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
          mode_d = stt_pkg::M_IDLE;
        end else if (c == "/" || c == "<" || c == ">" || c == "=" || c == "!" ||
                     c == "-") begin
          held_d = c; mode_d = stt_pkg::M_PEND;
        end else if (c == "#") begin
          wlen_d = '0; mode_d = stt_pkg::M_HASH;
        end else if (stt_pkg::is_alpha(c) || c == "_") begin
          word_d[0] = c; wlen_d = WLenW'(1);
          res[n] = f_txt(c); n = n + 3'd1;
          mode_d = stt_pkg::M_IDENT;
        end else if (stt_pkg::is_digit(c)) begin
          res[n] = f_txt(c); n = n + 3'd1;
          mode_d = stt_pkg::M_NUM;
        end else if (c == "\"") begin
          mode_d = stt_pkg::M_STR;
        end else if (c == ".") begin
          mode_d = stt_pkg::M_DOT;
        end else if (sk != stt_pkg::KIND_END) begin
          res[n] = f_txt(c); n = n + 3'd1;
          res[n] = f_rec(sk, line_q, col_q, stt_pkg::ERR_NONE);
          n = n + 3'd1;
        end else begin
          res[n] = f_rec(stt_pkg::KIND_END, line_q, col_q, stt_pkg::ERR_BADCHAR);
          n = n + 3'd1;
          halted_d = 1'b1;
        end
      end

      // End of source: end record, then rewind the positions
      if (eos && !halted_d) begin
        res[n] = f_rec(stt_pkg::KIND_END, line_q, col_q, stt_pkg::ERR_NONE);
        n = n + 3'd1;
        line_d = PosOne; col_d = PosOne; tok_line_d = PosOne; tok_col_d = PosOne;
        mode_d = stt_pkg::M_IDLE;
      end

      if (n != 3'd0) res[n - 3'd1].last = 1'b1;
    end
  end

  // Pack the burst for the queue
  always_comb begin
    ent.cnt = n;
    for (int i = 0; i < stt_pkg::MaxResults; i++) ent.recs[i] = res[i];
  end

  assign push_o      = fire && (n != 3'd0);
  assign push_data_o = ent;

  // Hold scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q     <= PosOne;
      col_q      <= PosOne;
      tok_line_q <= PosOne;
      tok_col_q  <= PosOne;
      mode_q     <= stt_pkg::M_IDLE;
      wlen_q     <= '0;
      halted_q   <= 1'b0;
    end else begin
      line_q     <= line_d;
      col_q      <= col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      mode_q     <= mode_d;
      wlen_q     <= wlen_d;
      halted_q   <= halted_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dot_line_q <= dot_line_d;
    dot_col_q  <= dot_col_d;
    held_q     <= held_d;
    word_q     <= word_d;
  end

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !push_o) else $error("push while halted");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt cleared without reset");
  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_q != '0) && (col_q != '0)) else $error("position counter hit zero");

endmodule

>>> rtl/core/stt_back.sv
// Back end: two-entry burst queue; one result beat per cycle while out_o is ready.
module stt_back #(
  parameter int PositionBits = stt_pkg::PositionBitsDefault,
  localparam int RecW = 19 + 2 * PositionBits,
  localparam int EntW = 3 + stt_pkg::MaxResults * RecW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [EntW-1:0] push_data_i,
  output logic            q_ready_o,
  stt_out_if.source       out_o
);

  typedef struct packed {
    logic                    last;
    logic                    is_token;
    logic [7:0]              text_byte;
    logic [5:0]              kind;
    logic [PositionBits-1:0] line;
    logic [PositionBits-1:0] col;
    logic [2:0]              err;
  } rec_t;

  typedef struct packed {
    logic [2:0] cnt;
    rec_t [stt_pkg::MaxResults-1:0] recs;
  } ent_t;

  ent_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic [2:0] idx_q;
  ent_t       cur;
  rec_t       beat;
  logic       fire, pop;

  assign cur       = ent_q[rp_q];
  assign beat      = cur.recs[idx_q];
  assign q_ready_o = (cnt_q != 2'd2);
  assign fire      = out_o.valid && out_o.ready;
  assign pop       = fire && (idx_q == cur.cnt - 3'd1);

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.is_token    = beat.is_token;
  assign out_o.text_byte   = beat.text_byte;
  assign out_o.token_kind  = beat.kind;
  assign out_o.start_line  = beat.line;
  assign out_o.start_col   = beat.col;
  assign out_o.error_code  = beat.err;
  assign out_o.last_of_run = beat.last;

  // Advance queue pointers and the beat index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
      idx_q <= 3'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
      if (pop) idx_q <= 3'd0;
      else if (fire) idx_q <= idx_q + 3'd1;
    end
  end

  // Store a burst
  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= push_data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> q_ready_o) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (cur.cnt != 3'd0) && (idx_q < cur.cnt)) else $error("beat index past burst");
  a_last_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> (out_o.last_of_run == pop)) else $error("last flag and pop disagree");

endmodule

>>> rtl/core/source_text_tokenizer.sv
// Source text tokenizer top level: front scanner, burst queue and output stage.
//
// Channel in_i carries one source beat: req_type (1 = end of source) and in_byte
// (zero also ends the source). Channel out_o carries result beats: token text
// bytes (is_token = 0) and token records (is_token = 1) with kind, start line,
// start column and error code; last_of_run marks the final beat of one input.
// Each input byte is scanned in the cycle it is accepted and produces zero to
// five result beats. If the queue is empty, the first beat shows on out_o the
// cycle after acceptance; beats then leave at one per cycle while out_o is
// ready. A two-entry burst queue sits between the scanner and the output, so
// input is taken every cycle while a queue slot is free; sustained rate is set
// by the output at one beat per cycle. When out_o stalls, the queue fills and
// in_i.ready drops until a burst drains. Reset clears positions to line 1,
// column 1, empties the queue and clears the halt. An error record halts the
// block: later inputs are taken and produce nothing until reset.
module source_text_tokenizer #(
  parameter int KeywordMaxLen = stt_pkg::KeywordMaxLenDefault,
  parameter int PositionBits  = stt_pkg::PositionBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);

  localparam int RecW = 19 + 2 * PositionBits;
  localparam int EntW = 3 + stt_pkg::MaxResults * RecW;

  logic            push;
  logic [EntW-1:0] push_data;
  logic            q_ready;

  stt_front #(
    .KeywordMaxLen(KeywordMaxLen),
    .PositionBits (PositionBits)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_req_type_i(in_i.req_type),
    .in_byte_i    (in_i.in_byte),
    .in_ready_o   (in_i.ready),
    .push_o       (push),
    .push_data_o  (push_data),
    .q_ready_i    (q_ready)
  );

  stt_back #(
    .PositionBits(PositionBits)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .q_ready_o  (q_ready),
    .out_o      (out_o)
  );

endmodule

>>> tb/sv/testbench.sv
// Testbench for the source text tokenizer: random and directed source text, scoreboard check.
`timescale 1ns / 100ps

module testbench;

  localparam int          WatchdogLimit = 5000;
  localparam logic [15:0] PosMax        = 16'hFFFF;

  typedef struct {
    logic        is_tok;
    logic [7:0]  txt;
    logic [5:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [2:0]  err;
    logic        last;
  } beat_t;

  typedef struct {
    logic       eos;
    logic [7:0] ch;
    bit         drain_first;
  } src_byte_t;

  logic clk_i;
  logic rst_ni;

  stt_in_if       in_bus ();
  stt_out_if #(16) out_bus ();

  source_text_tokenizer u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  string kw_words [21] = '{"fn", "let", "mut", "if", "else", "while", "for", "in", "return",
                           "break", "continue", "true", "false", "and", "or", "not", "int",
                           "float", "bool", "string", "void"};

  src_byte_t pending_src[$];
  beat_t     expected_beats[$];
  beat_t     step_beats[$];
  int        mismatch_count;
  int        src_gap;
  int        snk_gap;
  int        quiet_cycles;

  // Scanner shadow state
  logic [15:0]     pos_line, pos_col, tok_line, tok_col, dot_line, dot_col;
  stt_pkg::mode_e  scan;
  logic [7:0]      held;
  string           word;
  int              word_len;
  bit              halted;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] punct_kind(logic [7:0] c);
    case (c)
      "(":     return stt_pkg::KIND_LPAREN;
      ")":     return stt_pkg::KIND_RPAREN;
      "{":     return stt_pkg::KIND_LBRACE;
      "}":     return stt_pkg::KIND_RBRACE;
      "[":     return stt_pkg::KIND_LBRACK;
      "]":     return stt_pkg::KIND_RBRACK;
      ",":     return stt_pkg::KIND_COMMA;
      ":":     return stt_pkg::KIND_COLON;
      ";":     return stt_pkg::KIND_SEMI;
      "+":     return stt_pkg::KIND_PLUS;
      "*":     return stt_pkg::KIND_STAR;
      "%":     return stt_pkg::KIND_PERCENT;
      default: return stt_pkg::KIND_END;
    endcase
  endfunction

  function automatic void put_beat(logic t, logic [7:0] b, logic [5:0] k, logic [15:0] l,
                                   logic [15:0] c, logic [2:0] e);
    beat_t x;
    if (step_beats.size() >= stt_pkg::MaxResults) return;
    x = '{is_tok: t, txt: b, kind: k, line: l, col: c, err: e, last: 1'b0};
    step_beats.insert(step_beats.size(), x);
  endfunction

  function automatic void put_text(logic [7:0] b);
    put_beat(1'b0, b, stt_pkg::KIND_END, '0, '0, stt_pkg::ERR_NONE);
  endfunction

  function automatic void put_record(logic [5:0] k);
    put_beat(1'b1, 8'd0, k, tok_line, tok_col, stt_pkg::ERR_NONE);
  endfunction

  function automatic void raise_error(logic [2:0] e, logic [15:0] l, logic [15:0] c);
    put_beat(1'b1, 8'd0, stt_pkg::KIND_END, l, c, e);
    halted = 1'b1;
    scan   = stt_pkg::M_IDLE;
  endfunction

  function automatic void word_push(logic [7:0] c);
    if (word_len < stt_pkg::KeywordMaxLenDefault) word = {word, string'(c)};
    if (word_len <= stt_pkg::KeywordMaxLenDefault) word_len++;
  endfunction

  function automatic bit word_equals(string s);
    return word_len == s.len() && word == s;
  endfunction

  function automatic logic [5:0] word_kind();
    for (int i = 0; i < 21; i++) begin
      if (word_equals(kw_words[i])) return stt_pkg::KIND_KW_BASE + 6'(i);
    end
    return stt_pkg::KIND_IDENT;
  endfunction

  // Close a held operator character; returns 1 when c was consumed
  function automatic bit close_operator(logic [7:0] c, bit has_c);
    logic [5:0] two, one;
    scan = stt_pkg::M_IDLE;
    if (held == "/") begin
      if (has_c && c == "/") begin
        scan = stt_pkg::M_COMMENT;
        return 1;
      end
      put_text("/");
      put_record(stt_pkg::KIND_SLASH);
      return 0;
    end
    if (held == "-") begin
      if (has_c && c == ">") begin
        put_text("-");
        put_text(">");
        put_record(stt_pkg::KIND_ARROW);
        return 1;
      end
      put_text("-");
      put_record(stt_pkg::KIND_MINUS);
      return 0;
    end
    case (held)
      "<":     begin two = stt_pkg::KIND_LE;   one = stt_pkg::KIND_LT;     end
      ">":     begin two = stt_pkg::KIND_GE;   one = stt_pkg::KIND_GT;     end
      "=":     begin two = stt_pkg::KIND_EQEQ; one = stt_pkg::KIND_ASSIGN; end
      default: begin two = stt_pkg::KIND_NE;   one = stt_pkg::KIND_NOT;    end
    endcase
    if (has_c && c == "=") begin
      put_text(held);
      put_text("=");
      put_record(two);
      return 1;
    end
    put_text(held);
    put_record(one);
    return 0;
  endfunction

  // Close a '#' word: 0 comment, 1 directive, 2 error
  function automatic int close_hash();
    scan = stt_pkg::M_IDLE;
    if (word_equals("profit")) begin
      put_record(stt_pkg::KIND_DIRECT);
      return 1;
    end
    if (word_equals("include")) begin
      raise_error(stt_pkg::ERR_INCLUDE, tok_line, tok_col);
      return 2;
    end
    return 0;
  endfunction

  function automatic void open_token(logic [7:0] c, logic [15:0] l, logic [15:0] col);
    logic [5:0] k;
    tok_line = l;
    tok_col  = col;
    scan     = stt_pkg::M_IDLE;
    k        = punct_kind(c);
    if (c == " " || c == "\t" || c == 8'h0D || c == "\n") return;
    if (c == "/" || c == "<" || c == ">" || c == "=" || c == "!" || c == "-") begin
      held = c;
      scan = stt_pkg::M_PEND;
    end else if (c == "#") begin
      word     = "";
      word_len = 0;
      scan     = stt_pkg::M_HASH;
    end else if (is_letter(c) || c == "_") begin
      word     = "";
      word_len = 0;
      word_push(c);
      put_text(c);
      scan = stt_pkg::M_IDENT;
    end else if (is_numeral(c)) begin
      put_text(c);
      scan = stt_pkg::M_NUM;
    end else if (c == "\"") begin
      scan = stt_pkg::M_STR;
    end else if (c == ".") begin
      scan = stt_pkg::M_DOT;
    end else if (k != stt_pkg::KIND_END) begin
      put_text(c);
      put_record(k);
    end else begin
      raise_error(stt_pkg::ERR_BADCHAR, l, col);
    end
  endfunction

  function automatic void scan_byte(logic [7:0] c, logic [15:0] l, logic [15:0] col);
    logic [7:0] d;
    int         r;
    case (scan)
      stt_pkg::M_IDENT: begin
        if (is_letter(c) || is_numeral(c) || c == "_") begin
          word_push(c);
          put_text(c);
        end else begin
          put_record(word_kind());
          open_token(c, l, col);
        end
      end
      stt_pkg::M_NUM: begin
        if (is_numeral(c)) put_text(c);
        else if (c == ".") begin
          dot_line = l;
          dot_col  = col;
          scan     = stt_pkg::M_NUMDOT;
        end else begin
          put_record(stt_pkg::KIND_INT);
          open_token(c, l, col);
        end
      end
      stt_pkg::M_NUMDOT: begin
        if (is_numeral(c)) begin
          put_text(".");
          put_text(c);
          scan = stt_pkg::M_FLOAT;
        end else begin
          put_record(stt_pkg::KIND_INT);
          tok_line = dot_line;
          tok_col  = dot_col;
          if (c == ".") scan = stt_pkg::M_DOTDOT;
          else raise_error(stt_pkg::ERR_DOT, dot_line, dot_col);
        end
      end
      stt_pkg::M_FLOAT: begin
        if (is_numeral(c)) put_text(c);
        else begin
          put_record(stt_pkg::KIND_DEC);
          open_token(c, l, col);
        end
      end
      stt_pkg::M_STR: begin
        if (c == "\"") begin
          put_record(stt_pkg::KIND_STRING);
          scan = stt_pkg::M_IDLE;
        end else if (c == "\\") scan = stt_pkg::M_ESC;
        else put_text(c);
      end
      stt_pkg::M_ESC: begin
        case (c)
          "n":     d = 8'h0A;
          "t":     d = 8'h09;
          "r":     d = 8'h0D;
          default: d = c;
        endcase
        put_text(d);
        scan = stt_pkg::M_STR;
      end
      stt_pkg::M_COMMENT: if (c == "\n") scan = stt_pkg::M_IDLE;
      stt_pkg::M_HASH: begin
        if (is_letter(c)) word_push(c);
        else begin
          r = close_hash();
          if (r == 1) open_token(c, l, col);
          else if (r == 0) scan = (c == "\n") ? stt_pkg::M_IDLE : stt_pkg::M_COMMENT;
        end
      end
      stt_pkg::M_PEND: if (!close_operator(c, 1)) open_token(c, l, col);
      stt_pkg::M_DOT: begin
        if (c == ".") scan = stt_pkg::M_DOTDOT;
        else raise_error(stt_pkg::ERR_DOT, tok_line, tok_col);
      end
      stt_pkg::M_DOTDOT: begin
        scan = stt_pkg::M_IDLE;
        put_text(".");
        put_text(".");
        if (c == "=") begin
          put_text("=");
          put_record(stt_pkg::KIND_RANGEQ);
        end else begin
          put_record(stt_pkg::KIND_RANGE);
          open_token(c, l, col);
        end
      end
      default: open_token(c, l, col);
    endcase
  endfunction

  function automatic void end_source();
    int r;
    bit b;
    case (scan)
      stt_pkg::M_IDENT:  put_record(word_kind());
      stt_pkg::M_NUM:    put_record(stt_pkg::KIND_INT);
      stt_pkg::M_NUMDOT: begin
        put_record(stt_pkg::KIND_INT);
        raise_error(stt_pkg::ERR_DOT, dot_line, dot_col);
      end
      stt_pkg::M_FLOAT:  put_record(stt_pkg::KIND_DEC);
      stt_pkg::M_STR, stt_pkg::M_ESC: raise_error(stt_pkg::ERR_UNTERM, tok_line, tok_col);
      stt_pkg::M_HASH:   r = close_hash();
      stt_pkg::M_PEND:   b = close_operator(8'd0, 0);
      stt_pkg::M_DOT:    raise_error(stt_pkg::ERR_DOT, tok_line, tok_col);
      stt_pkg::M_DOTDOT: begin
        put_text(".");
        put_text(".");
        put_record(stt_pkg::KIND_RANGE);
      end
      default: ;
    endcase
    if (halted) return;
    put_beat(1'b1, 8'd0, stt_pkg::KIND_END, pos_line, pos_col, stt_pkg::ERR_NONE);
    pos_line = 1;
    pos_col  = 1;
    tok_line = 1;
    tok_col  = 1;
    scan     = stt_pkg::M_IDLE;
  endfunction

  // Predict the beats of one accepted source beat and queue them
  function automatic void tokenize_step(logic eos, logic [7:0] c);
    logic [15:0] l, col;
    step_beats.delete();
    if (halted) return;
    if (eos || c == 8'd0) end_source();
    else begin
      l   = pos_line;
      col = pos_col;
      if (c == "\n") begin
        if (pos_line != PosMax) pos_line++;
        pos_col = 1;
      end else if (pos_col != PosMax) pos_col++;
      scan_byte(c, l, col);
    end
    if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
    foreach (step_beats[i]) expected_beats.insert(expected_beats.size(), step_beats[i]);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Source driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid    <= 1'b0;
      in_bus.req_type <= 1'b0;
      in_bus.in_byte  <= 8'd0;
      src_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) tokenize_step(in_bus.req_type, in_bus.in_byte);
      if (!in_bus.valid || in_bus.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending_src.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else if (pending_src[0].drain_first && expected_beats.size() != 0) begin
          in_bus.valid <= 1'b0;
        end else if (pending_src.size() > 60 && $urandom_range(7) == 0) begin
          src_gap = $urandom_range(0, 13);
          in_bus.valid <= 1'b0;
        end else begin
          in_bus.valid    <= 1'b1;
          in_bus.req_type <= pending_src[0].eos;
          in_bus.in_byte  <= pending_src[0].ch;
          void'(pending_src.pop_front());
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    beat_t w;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_beats.size() == 0) begin
          report("beat with none expected, kind", 32'(out_bus.token_kind), 0);
        end else begin
          w = expected_beats.pop_front();
          if (out_bus.is_token !== w.is_tok)
            report("is_token", 32'(out_bus.is_token), 32'(w.is_tok));
          if (out_bus.text_byte !== w.txt)
            report("text_byte", 32'(out_bus.text_byte), 32'(w.txt));
          if (out_bus.token_kind !== w.kind)
            report("token_kind", 32'(out_bus.token_kind), 32'(w.kind));
          if (out_bus.start_line !== w.line)
            report("start_line", 32'(out_bus.start_line), 32'(w.line));
          if (out_bus.start_col !== w.col)
            report("start_col", 32'(out_bus.start_col), 32'(w.col));
          if (out_bus.error_code !== w.err)
            report("error_code", 32'(out_bus.error_code), 32'(w.err));
          if (out_bus.last_of_run !== w.last)
            report("last_of_run", 32'(out_bus.last_of_run), 32'(w.last));
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_bus.ready <= 1'b0;
      end else if (pending_src.size() > 60 && $urandom_range(7) == 0) begin
        snk_gap = $urandom_range(0, 13);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic add_ch(logic [7:0] b, bit hold = 0);
    src_byte_t s;
    s = '{eos: 1'b0, ch: b, drain_first: hold};
    pending_src.insert(pending_src.size(), s);
  endtask

  task automatic add_str(string t);
    foreach (t[i]) add_ch(t[i]);
  endtask

  task automatic add_eos();
    src_byte_t s;
    if ($urandom_range(1)) s = '{eos: 1'b1, ch: 8'($urandom), drain_first: 0};
    else s = '{eos: 1'b0, ch: 8'd0, drain_first: 0};
    pending_src.insert(pending_src.size(), s);
  endtask

  function automatic logic [7:0] free_byte(bit no_newline);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == "\"" || b == "\\" || (no_newline && b == "\n"));
    return b;
  endfunction

  // Append one well-formed token with random content, plus an optional separator
  task automatic add_token();
    string alnum, ops [24];
    int    n;
    alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    ops   = '{"(", ")", "{", "}", "[", "]", "<=", "<", ">=", ">", ",", ":", ";", "+",
              "->", "-", "*", "/", "%", "==", "=", "!=", "..=", ".."};
    case ($urandom_range(9))
      0: add_str(kw_words[$urandom_range(20)]);
      1: begin
        add_ch(alnum[$urandom_range(52)]);
        n = $urandom_range(0, 11);
        repeat (n) add_ch(alnum[$urandom_range(62)]);
      end
      2: repeat ($urandom_range(1, 6)) add_ch(8'("0") + 8'($urandom_range(9)));
      3: begin
        add_ch(8'("0") + 8'($urandom_range(9)));
        add_ch(".");
        repeat ($urandom_range(1, 3)) add_ch(8'("0") + 8'($urandom_range(9)));
      end
      4: begin
        add_ch("\"");
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(3) == 0) begin
            add_ch("\\");
            case ($urandom_range(5))
              0: add_ch("n");
              1: add_ch("t");
              2: add_ch("r");
              3: add_ch("\\");
              4: add_ch("\"");
              default: add_ch(free_byte(0));
            endcase
          end else add_ch(free_byte(0));
        end
        add_ch("\"");
      end
      5, 6: add_str(ops[$urandom_range(23)]);
      7: begin
        add_str("//");
        repeat ($urandom_range(0, 10)) add_ch(free_byte(1));
        add_ch("\n");
      end
      8: begin
        if ($urandom_range(1)) add_str("#profit");
        else add_str("#note x\n");
      end
      default: begin
        add_ch(8'("0") + 8'($urandom_range(9)));
        add_str("..");
        add_ch(8'("0") + 8'($urandom_range(9)));
      end
    endcase
    case ($urandom_range(7))
      0, 1: ;
      2: add_ch("\t");
      3: add_ch(8'h0D);
      4: add_ch("\n");
      default: add_ch(" ");
    endcase
  endtask

  initial begin
    rst_ni          = 1'b0;
    mismatch_count  = 0;
    pos_line = 1; pos_col = 1; tok_line = 1; tok_col = 1; dot_line = 0; dot_col = 0;
    scan = stt_pkg::M_IDLE; held = 8'd0; word = ""; word_len = 0; halted = 0;

    // Directed: token shapes, escapes, high bytes, hash forms, trailing operators
    add_str("fn Ab_9 continuex= 12.5;\"\\n\\q");
    add_ch(8'hFF);
    add_str("\" <=>=!===->-..=3..4//c\n#profit(#zap q\n");
    add_eos();
    add_str("a-");
    add_eos();
    add_str("x/");
    add_eos();
    add_str("7.");
    add_ch(".", 0);
    add_eos();

    // Random well-formed text with occasional end of source
    add_ch(" ", 1);
    while (pending_src.size() < 280) begin
      add_token();
      if ($urandom_range(29) == 0) add_eos();
    end

    // Close with one randomly chosen error, then bytes that must be ignored
    add_ch(" ", 1);
    case ($urandom_range(5))
      0: begin add_str("\"ab"); add_eos(); end
      1: add_str("#include ");
      2: add_str("x . ");
      3: add_str("7.q");
      4: add_str("y @");
      default: add_ch(8'h80 + 8'($urandom_range(127)));
    endcase
    add_str("fn 1 ");
    add_eos();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_src.size() == 0 && !in_bus.valid);
    wait (expected_beats.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
